// ===== rtl/core/tlpf_pkg.sv =====
// Shared types, constants and helpers of the tile layer pixel fetch block.
package tlpf_pkg;

   // Geometry follows from the fixed field widths of the item
   localparam int TILE_W      = 8;
   localparam int TILE_H      = 8;
   localparam int SHEET_COLS  = 16;
   localparam int SCREEN_COLS = 64;
   localparam int SCREEN_ROWS = 32;

   localparam int TILE_BITS = 8;
   localparam int TW_BITS   = $clog2(TILE_W);
   localparam int TH_BITS   = $clog2(TILE_H);
   localparam int SC_BITS   = $clog2(SHEET_COLS);
   localparam int SCC_BITS  = $clog2(SCREEN_COLS);
   localparam int SCR_BITS  = $clog2(SCREEN_ROWS);

   localparam int SHEET_AW    = TILE_BITS + TW_BITS + TH_BITS;
   localparam int CELL_AW     = SCC_BITS + SCR_BITS;
   localparam int SHEET_DEPTH = 1 << SHEET_AW;
   localparam int CELL_DEPTH  = 1 << CELL_AW;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 8;

   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   // Input commands as carried in req_tuser
   localparam logic [1:0] CMD_SHEET_WR = 2'd0;
   localparam logic [1:0] CMD_CELL_WR  = 2'd1;
   localparam logic [1:0] CMD_FETCH    = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_SCROLL_X      = 2'd0;
   localparam logic [1:0] REG_SCROLL_Y      = 2'd1;
   localparam logic [1:0] REG_TARGET_WIDTH  = 2'd2;
   localparam logic [1:0] REG_TARGET_HEIGHT = 2'd3;

   typedef enum logic [1:0] {
      OP_SHEET_WR = 2'd0,
      OP_CELL_WR  = 2'd1,
      OP_FETCH    = 2'd2
   } op_kind_type;

   typedef struct packed {
      logic [2:0] scroll_x;
      logic [2:0] scroll_y;
      logic [9:0] target_width;
      logic [8:0] target_height;
   } cfg_type;

   typedef struct packed {
      op_kind_type          kind;
      logic [SHEET_AW-1:0]  sheet_addr;
      logic [CELL_AW-1:0]   cell_addr;
      logic [7:0]           data;
      logic                 hit;
      logic [TW_BITS-1:0]   off_x;
      logic [TH_BITS-1:0]   off_y;
   } op_type;

   typedef struct packed {
      logic clear_busy;
   } back_status_type;

   // Sheet byte address: tile rows of the sheet above, pixel row, tile column, pixel column
   function automatic logic [SHEET_AW-1:0] sheet_addr_f(input logic [TILE_BITS-1:0] tile,
                                                      input logic [TW_BITS-1:0] col,
                                                      input logic [TH_BITS-1:0] row);
      sheet_addr_f = {tile[TILE_BITS-1:SC_BITS], row, tile[SC_BITS-1:0], col};
   endfunction

endpackage

// ===== rtl/core/tlpf_front.sv =====
// Front end: accepts items, classifies commands, works out addresses and clipping.
module tlpf_front (
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tlpf_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]                      req_tuser,
   input  tlpf_pkg::cfg_type               cfg,
   input  logic                            clear_busy,
   input  logic                            q_full,
   output logic                            push,
   output tlpf_pkg::op_type                push_op
);
   import tlpf_pkg::*;

   localparam int TILE_LSB  = 0;
   localparam int PCOL_LSB  = 8;
   localparam int PROW_LSB  = 11;
   localparam int PDATA_LSB = 14;
   localparam int CCOL_LSB  = 22;
   localparam int CROW_LSB  = 28;
   localparam int TX_LSB    = 33;
   localparam int TY_LSB    = 42;

   logic [7:0] tile;
   logic [8:0] tx;
   logic [7:0] ty;
   logic [8:0] lx;
   logic [7:0] ly;
   logic       hit;
   logic       accept;

   assign tile = req_tdata[TILE_LSB +: 8];
   assign tx   = req_tdata[TX_LSB +: 9];
   assign ty   = req_tdata[TY_LSB +: 8];

   assign lx = tx - 9'(cfg.scroll_x);
   assign ly = ty - 8'(cfg.scroll_y);

   // grid always spans the whole 9x8-bit target range, so only the edges clip
   assign hit = ({1'b0, tx} < cfg.target_width) && ({1'b0, ty} < cfg.target_height) &&
                (tx >= 9'(cfg.scroll_x)) && (ty >= 8'(cfg.scroll_y));

   assign req_tready = !clear_busy && !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      push_op.kind       = OP_FETCH;
      push_op.sheet_addr = sheet_addr_f(tile, req_tdata[PCOL_LSB +: TW_BITS],
                                        req_tdata[PROW_LSB +: TH_BITS]);
      push_op.cell_addr  = {ly[TH_BITS +: SCR_BITS], lx[TW_BITS +: SCC_BITS]};
      push_op.data       = req_tdata[PDATA_LSB +: 8];
      push_op.hit        = hit;
      push_op.off_x      = lx[TW_BITS-1:0];
      push_op.off_y      = ly[TH_BITS-1:0];
      push               = 1'b0;
      case (req_tuser)
         CMD_SHEET_WR: begin
            push_op.kind = OP_SHEET_WR;
            push         = accept;
         end
         CMD_CELL_WR: begin
            push_op.kind      = OP_CELL_WR;
            push_op.cell_addr = {req_tdata[CROW_LSB +: SCR_BITS], req_tdata[CCOL_LSB +: SCC_BITS]};
            push_op.data      = tile;
            push              = accept;
         end
         CMD_FETCH: begin
            push_op.kind = OP_FETCH;
            push         = accept;
         end
         default: begin
            // unused command: taken and dropped
            push = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/core/tlpf_queue.sv =====
// Short queue of classified items between the front end and the back end.
module tlpf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tlpf_pkg::op_type push_op,
   input  logic             pop,
   output logic             empty,
   output logic             full,
   output tlpf_pkg::op_type head_op
);
   import tlpf_pkg::*;

   op_type          entry_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]   count_ff, count_in;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (Q_AW+1)'(Q_DEPTH));
   assign head_op = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== rtl/core/tlpf_back.sv =====
// Back end: tile sheet and screen cell stores, clearing pass, fetch pipeline and result register.
module tlpf_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   input  tlpf_pkg::op_type                head_op,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tlpf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser,
   output tlpf_pkg::back_status_type       status
);
   import tlpf_pkg::*;

   logic [7:0] sheet_mem [SHEET_DEPTH];
   logic [7:0] cell_mem  [CELL_DEPTH];

   logic                clear_busy_ff, clear_busy_in;
   logic [SHEET_AW-1:0] clear_cnt_ff, clear_cnt_in;

   logic [7:0]          cell_rd_ff;
   logic [7:0]          sheet_rd_ff;
   logic [SHEET_AW-1:0] sheet_rd_addr;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_hit_ff;
   logic [TW_BITS-1:0] s1_off_x_ff;
   logic [TH_BITS-1:0] s1_off_y_ff;
   logic               s2_valid_ff;
   logic               s2_hit_ff;
   logic               out_valid_ff;
   logic [7:0]         out_data_ff;
   logic               out_cov_ff;

   logic adv;
   logic sheet_wr;
   logic cell_wr;

   // the whole pipeline moves together, so stores change only in item order
   assign adv      = !out_valid_ff || rsp_tready;
   assign pop      = adv && !q_empty && !clear_busy_ff;
   assign sheet_wr = pop && (head_op.kind == OP_SHEET_WR);
   assign cell_wr  = pop && (head_op.kind == OP_CELL_WR);
   assign s1_valid_in = pop && (head_op.kind == OP_FETCH);

   assign sheet_rd_addr = sheet_addr_f(cell_rd_ff, s1_off_x_ff, s1_off_y_ff);

   always_comb begin
      clear_cnt_in  = clear_cnt_ff;
      clear_busy_in = clear_busy_ff;
      if (clear_busy_ff) begin
         clear_cnt_in = clear_cnt_ff + 1'b1;
         if (clear_cnt_ff == SHEET_AW'(SHEET_DEPTH - 1)) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_cnt_ff  <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_cnt_ff  <= clear_cnt_in;
      end
   end

   // cell store: a read by a later item sees the write of an earlier item
   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         cell_mem[clear_cnt_ff[CELL_AW-1:0]] <= '0;
      end else if (cell_wr) begin
         cell_mem[head_op.cell_addr] <= head_op.data;
      end
      if (adv) begin
         cell_rd_ff <= cell_mem[head_op.cell_addr];
      end
   end

   // sheet store: read returns the old byte when a later item writes the same edge
   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         sheet_mem[clear_cnt_ff] <= '0;
      end else if (sheet_wr) begin
         sheet_mem[head_op.sheet_addr] <= head_op.data;
      end
      if (adv) begin
         sheet_rd_ff <= sheet_mem[sheet_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_hit_ff   <= head_op.hit;
         s1_off_x_ff <= head_op.off_x;
         s1_off_y_ff <= head_op.off_y;
         s2_hit_ff   <= s1_hit_ff;
         out_data_ff <= s2_hit_ff ? sheet_rd_ff : 8'd0;
         out_cov_ff  <= s2_hit_ff;
      end
   end

   assign rsp_tvalid        = out_valid_ff;
   assign rsp_tdata         = out_data_ff;
   assign rsp_tuser         = out_cov_ff;
   assign status.clear_busy = clear_busy_ff;

endmodule

// ===== rtl/core/tile_layer_pixel_fetch.sv =====
// Top level of the tile layer pixel fetch block: register port, front end, queue, back end.
//
//   channel  dir  payload                                     handshake
//   req_     in   tuser cmd, tdata write / fetch fields       tvalid / tready
//   rsp_     out  tdata pixel_value, tuser covered            tvalid / tready
//   csr_     in   scroll_x, scroll_y, target_width/height     APB, pready tied high
//
// One item per cycle sustained unless rsp_ stalls or the clearing pass runs; a fetch
// result passes the queue slot, cell store read, sheet store read and result register.
// After reset a clearing pass zeroes both stores (one sheet byte and one cell a cycle);
// req_tready stays low meanwhile, register writes are taken. A shown result with
// rsp_tready low freezes the back pipeline; the four-entry queue takes items until full.
module tile_layer_pixel_fetch (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tile_number[7:0], pixel_col[10:8], pixel_row[13:11], pixel_data[21:14],
   // cell_col[27:22], cell_row[32:28], target_x[41:33], target_y[49:42], zero[55:50]
   input  logic [tlpf_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // pixel_value[7:0]
   output logic [tlpf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // covered[0]
   output logic                            rsp_tuser,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [3:0]                      csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import tlpf_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            csr_wr;
   logic            push;
   op_type          push_op;
   logic            pop;
   logic            q_empty;
   logic            q_full;
   op_type          head_op;
   back_status_type status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_SCROLL_X:      cfg_in.scroll_x      = csr_pwdata[2:0];
            REG_SCROLL_Y:      cfg_in.scroll_y      = csr_pwdata[2:0];
            REG_TARGET_WIDTH:  cfg_in.target_width  = csr_pwdata[9:0];
            REG_TARGET_HEIGHT: cfg_in.target_height = csr_pwdata[8:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scroll_x      <= 3'd0;
         cfg_ff.scroll_y      <= 3'd0;
         cfg_ff.target_width  <= 10'd512;
         cfg_ff.target_height <= 9'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_SCROLL_X:      csr_prdata = 32'(cfg_ff.scroll_x);
         REG_SCROLL_Y:      csr_prdata = 32'(cfg_ff.scroll_y);
         REG_TARGET_WIDTH:  csr_prdata = 32'(cfg_ff.target_width);
         REG_TARGET_HEIGHT: csr_prdata = 32'(cfg_ff.target_height);
         default:           csr_prdata = '0;
      endcase
   end

   tlpf_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg_ff),
      .clear_busy (status.clear_busy),
      .q_full     (q_full),
      .push       (push),
      .push_op    (push_op)
   );

   tlpf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .empty   (q_empty),
      .full    (q_full),
      .head_op (head_op)
   );

   tlpf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .head_op    (head_op),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .status     (status)
   );

   a_no_accept_while_clearing : assert property (@(posedge clock) disable iff (reset)
      status.clear_busy |-> !req_tready)
      else $error("item accepted during clearing pass");

   a_no_result_while_clearing : assert property (@(posedge clock) disable iff (reset)
      status.clear_busy |-> !rsp_tvalid)
      else $error("result shown during clearing pass");

   a_uncovered_is_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("uncovered pixel with nonzero value");

endmodule

// ===== tb/tlpf_checker.sv =====
// Checker for the tile layer pixel fetch block: mirrors the stores and compares results.
`timescale 1ns / 1ps

module tlpf_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [tlpf_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]                      req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [tlpf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tuser,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [3:0]                      csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   input  logic [31:0]                     csr_prdata,
   input  logic                            csr_pready,
   output int                              fail_count,
   output int                              pending
);
   import tlpf_pkg::*;

   typedef struct packed {
      logic [7:0] pixel;
      logic       covered;
   } pixel_result_type;

   logic [7:0]       sheet_mirror [SHEET_DEPTH];
   logic [7:0]       cell_mirror  [CELL_DEPTH];
   logic [2:0]       scroll_x_r;
   logic [2:0]       scroll_y_r;
   logic [9:0]       width_r;
   logic [8:0]       height_r;
   pixel_result_type pixels_due [$];

   function automatic int sheet_byte_index(input int tile, input int col, input int row);
      return ((tile / SHEET_COLS) * TILE_H + row) * (SHEET_COLS * TILE_W)
             + (tile % SHEET_COLS) * TILE_W + col;
   endfunction

   // Which sheet byte, if any, lands on target pixel (x, y)
   function automatic pixel_result_type layer_pixel(input int x, input int y);
      pixel_result_type r;
      int ox, oy, lx, ly, cc, cr;
      ox = int'(scroll_x_r) % TILE_W;
      oy = int'(scroll_y_r) % TILE_H;
      r.pixel   = 8'd0;
      r.covered = 1'b0;
      if (x < int'(width_r) && y < int'(height_r) && x >= ox && y >= oy) begin
         lx = x - ox;
         ly = y - oy;
         cc = lx / TILE_W;
         cr = ly / TILE_H;
         if (cc < SCREEN_COLS && cr < SCREEN_ROWS) begin
            r.covered = 1'b1;
            r.pixel   = sheet_mirror[sheet_byte_index(int'(cell_mirror[cr * SCREEN_COLS + cc]),
                                                      lx % TILE_W, ly % TILE_H)];
         end
      end
      return r;
   endfunction

   function automatic logic [31:0] reg_value(input logic [1:0] idx);
      case (idx)
         REG_SCROLL_X:     return {29'd0, scroll_x_r};
         REG_SCROLL_Y:     return {29'd0, scroll_y_r};
         REG_TARGET_WIDTH: return {22'd0, width_r};
         default:          return {23'd0, height_r};
      endcase
   endfunction

   always @(posedge clock) begin
      pixel_result_type want;
      int               tile;
      if (reset) begin
         scroll_x_r = 3'd0;
         scroll_y_r = 3'd0;
         width_r    = 10'd512;
         height_r   = 9'd256;
         foreach (sheet_mirror[i]) sheet_mirror[i] = 8'd0;
         foreach (cell_mirror[i]) cell_mirror[i] = 8'd0;
         pixels_due.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[3:2])
                  REG_SCROLL_X:     scroll_x_r = csr_pwdata[2:0];
                  REG_SCROLL_Y:     scroll_y_r = csr_pwdata[2:0];
                  REG_TARGET_WIDTH: width_r    = csr_pwdata[9:0];
                  default:          height_r   = csr_pwdata[8:0];
               endcase
            end else if (csr_prdata !== reg_value(csr_paddr[3:2])) begin
               $error("csr_prdata mismatch: expected %0d, actual %0d",
                      reg_value(csr_paddr[3:2]), csr_prdata);
               fail_count++;
            end
         end

         if (rsp_tvalid && rsp_tready) begin
            if (pixels_due.size() == 0) begin
               $error("result with no fetch outstanding: pixel_value %0d covered %0d",
                      rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               want = pixels_due.pop_front();
               if (rsp_tdata !== want.pixel) begin
                  $error("pixel_value mismatch: expected %0d, actual %0d",
                         want.pixel, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser !== want.covered) begin
                  $error("covered mismatch: expected %0d, actual %0d",
                         want.covered, rsp_tuser);
                  fail_count++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            tile = int'(req_tdata[7:0]);
            case (req_tuser)
               CMD_SHEET_WR:
                  sheet_mirror[sheet_byte_index(tile, int'(req_tdata[10:8]),
                                                int'(req_tdata[13:11]))] = req_tdata[21:14];
               CMD_CELL_WR:
                  cell_mirror[int'(req_tdata[32:28]) * SCREEN_COLS + int'(req_tdata[27:22])] =
                     req_tdata[7:0];
               CMD_FETCH:
                  pixels_due.push_back(layer_pixel(int'(req_tdata[41:33]),
                                                   int'(req_tdata[49:42])));
               default: ;  // unused command, dropped by the block
            endcase
         end
      end
      pending = pixels_due.size();
   end

endmodule

// ===== tb/tile_layer_pixel_fetch_tb.sv =====
// Testbench top of the tile layer pixel fetch block: stimulus, register phases and verdict.
`timescale 1ns / 1ps

module tile_layer_pixel_fetch_tb;
   import tlpf_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int         N_PHASES   = 7;
   localparam int         PHASE_ITEMS = 104;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = CMD_SHEET_WR;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [3:0]            csr_paddr = 4'd0;
   logic [31:0]           csr_pwdata = 32'd0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int pending;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int items_sent    = 0;
   int fetches_sent  = 0;
   int cur_w         = 512;
   int cur_h         = 256;

   logic [7:0] tile_pool [6] = '{8'd0, 8'd1, 8'd17, 8'd128, 8'd254, 8'd255};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tile_layer_pixel_fetch u_top (.*);

   tlpf_checker u_check (.*);

   always @(negedge clock) rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);

   initial begin
      #3_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic csr_access(input logic write, input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock) csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_fields(input logic [1:0] cmd, input logic [7:0] tile,
                              input logic [2:0] pcol, input logic [2:0] prow,
                              input logic [7:0] pdata, input logic [5:0] ccol,
                              input logic [4:0] crow, input logic [8:0] tx,
                              input logic [7:0] ty);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'd0, ty, tx, crow, ccol, pdata, prow, pcol, tile};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (cmd == CMD_FETCH) fetches_sent++;
   endtask

   task automatic hold_until_drained();
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic send_random_item();
      logic [1:0] cmd;
      logic [7:0] tile;
      logic [5:0] ccol;
      logic [4:0] crow;
      int         pick, tx, ty;
      pick = $urandom_range(0, 99);
      if (pick < 30)      cmd = CMD_SHEET_WR;
      else if (pick < 45) cmd = CMD_CELL_WR;
      else if (pick < 96) cmd = CMD_FETCH;
      else                cmd = CMD_UNUSED;
      tile = 8'($urandom);
      ccol = 6'($urandom);
      crow = 5'($urandom);
      // keep most writes and fetches on a few tiles and cells so fetches see written data
      if ($urandom_range(0, 3) != 0) tile = tile_pool[$urandom_range(0, 5)];
      if ($urandom_range(0, 3) != 0) begin
         ccol = 6'($urandom_range(0, 7));
         crow = 5'($urandom_range(0, 5));
      end
      case ($urandom_range(0, 7))
         0, 1, 2, 3: begin
            tx = $urandom_range(0, 71);
            ty = $urandom_range(0, 55);
         end
         4: begin
            tx = 511 - $urandom_range(0, 9);
            ty = 255 - $urandom_range(0, 9);
         end
         5: begin  // around the clip edges
            tx = cur_w - 2 + $urandom_range(0, 3);
            ty = cur_h - 2 + $urandom_range(0, 3);
         end
         6: begin
            tx = $urandom_range(0, 9);
            ty = $urandom_range(0, 9);
         end
         default: begin
            tx = $urandom_range(0, 511);
            ty = $urandom_range(0, 255);
         end
      endcase
      if (tx < 0) tx = 0;
      if (tx > 511) tx = 511;
      if (ty < 0) ty = 0;
      if (ty > 255) ty = 255;
      send_fields(cmd, tile, 3'($urandom), 3'($urandom), 8'($urandom), ccol, crow,
                  9'(tx), 8'(ty));
   endtask

   task automatic set_registers(input int sx, input int sy, input int w, input int h);
      csr_access(1'b1, REG_SCROLL_X, sx);
      csr_access(1'b1, REG_SCROLL_Y, sy);
      csr_access(1'b1, REG_TARGET_WIDTH, w);
      csr_access(1'b1, REG_TARGET_HEIGHT, h);
      cur_w = w;
      cur_h = h;
   endtask

   initial begin
      int k;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int ph = 0; ph < N_PHASES; ph++) begin
         send_idle_pct = (ph <= 2) ? 13 : (ph <= 4) ? 47 : 0;
         rsp_idle_pct  = (ph <= 2) ? 47 : (ph <= 4) ? 13 : 0;
         if (ph > 0) begin
            hold_until_drained();
            // writes give no result, so let the pipeline empty before touching registers
            repeat (16) @(negedge clock);
         end
         case (ph)
            1: set_registers(7, 7, 512, 256);
            2: set_registers(0, 0, 1, 1);
            3: set_registers(3, 5, 300, 200);
            4: set_registers(6, 2, 0, 0);
            5: set_registers(7, 0, 1023, 511);
            6: set_registers($urandom_range(0, 7), $urandom_range(0, 7),
                             $urandom_range(1, 512), $urandom_range(1, 256));
            default: ;
         endcase
         for (int r = 0; r < 4; r++) csr_access(1'b0, r[1:0], 32'd0);

         if (ph == 0) begin
            send_fields(CMD_SHEET_WR, 8'd0, 3'd0, 3'd0, 8'hFF, 6'd0, 5'd0, 9'd0, 8'd0);
            send_fields(CMD_SHEET_WR, 8'd1, 3'd7, 3'd0, 8'h00, 6'd63, 5'd31, 9'd511, 8'd255);
            send_fields(CMD_SHEET_WR, 8'd255, 3'd7, 3'd7, 8'hA5, 6'd0, 5'd0, 9'd0, 8'd0);
            send_fields(CMD_SHEET_WR, 8'd255, 3'd0, 3'd0, 8'h5A, 6'd0, 5'd0, 9'd0, 8'd0);
            send_fields(CMD_SHEET_WR, 8'd128, 3'd5, 3'd2, 8'h81, 6'd0, 5'd0, 9'd0, 8'd0);
            send_fields(CMD_CELL_WR, 8'd255, 3'd0, 3'd0, 8'd0, 6'd63, 5'd31, 9'd0, 8'd0);
            send_fields(CMD_CELL_WR, 8'd255, 3'd7, 3'd7, 8'hFF, 6'd0, 5'd0, 9'd511, 8'd255);
            send_fields(CMD_CELL_WR, 8'd0, 3'd0, 3'd0, 8'd0, 6'd1, 5'd0, 9'd0, 8'd0);
            send_fields(CMD_CELL_WR, 8'd128, 3'd0, 3'd0, 8'd0, 6'd2, 5'd1, 9'd0, 8'd0);
            send_fields(CMD_FETCH, 8'd0, 3'd0, 3'd0, 8'd0, 6'd0, 5'd0, 9'd0, 8'd0);
            send_fields(CMD_FETCH, 8'd0, 3'd0, 3'd0, 8'd0, 6'd0, 5'd0, 9'd7, 8'd7);
            send_fields(CMD_FETCH, 8'd0, 3'd0, 3'd0, 8'd0, 6'd0, 5'd0, 9'd8, 8'd0);
            send_fields(CMD_FETCH, 8'hFF, 3'd7, 3'd7, 8'hFF, 6'd63, 5'd31, 9'd511, 8'd255);
            send_fields(CMD_FETCH, 8'd0, 3'd0, 3'd0, 8'd0, 6'd0, 5'd0, 9'd504, 8'd248);
            send_fields(CMD_FETCH, 8'd0, 3'd0, 3'd0, 8'd0, 6'd0, 5'd0, 9'd21, 8'd10);
            send_fields(CMD_UNUSED, 8'($urandom), 3'($urandom), 3'($urandom), 8'($urandom),
                        6'($urandom), 5'($urandom), 9'($urandom), 8'($urandom));
            send_fields(CMD_UNUSED, 8'hFF, 3'd7, 3'd7, 8'hFF, 6'd63, 5'd31, 9'd511, 8'd255);
            send_fields(CMD_FETCH, 8'd0, 3'd0, 3'd0, 8'd0, 6'd0, 5'd0, 9'd100, 8'd100);
            send_fields(CMD_FETCH, 8'd0, 3'd0, 3'd0, 8'd0, 6'd0, 5'd0, 9'd511, 8'd0);
            send_fields(CMD_FETCH, 8'd0, 3'd0, 3'd0, 8'd0, 6'd0, 5'd0, 9'd0, 8'd255);
            // overwrite a shown pixel, then fetch it again
            send_fields(CMD_SHEET_WR, 8'd255, 3'd0, 3'd0, 8'h3C, 6'd0, 5'd0, 9'd0, 8'd0);
            send_fields(CMD_FETCH, 8'd0, 3'd0, 3'd0, 8'd0, 6'd0, 5'd0, 9'd0, 8'd0);
         end else begin
            for (int n = 0; n < PHASE_ITEMS; n++) begin
               if (ph == 3 && n == PHASE_ITEMS / 2) hold_until_drained();
               send_random_item();
            end
         end
      end

      hold_until_drained();
      k = 0;
      while (pending != 0 && k < 2000) begin
         @(negedge clock);
         k++;
      end
      repeat (20) @(negedge clock);

      $display("Run covered %0d items, %0d of them pixel fetches, over %0d register settings",
               items_sent, fetches_sent, N_PHASES);
      $display("with sender and receiver stalls in both ratios and a stretch without stalls");
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         if (pending != 0) $error("%0d fetch results never arrived", pending);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
